### hw/rtl/sdtq_pkg.sv
// Shared types and codes for the sorted deadline timer queue.
package sdtq_pkg;

    localparam int IDX_W = 8;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_ALLOC  = 3'd1,
        MODE_SETUP  = 3'd2,
        MODE_ARM    = 3'd3,
        MODE_CANCEL = 3'd4,
        MODE_FREE   = 3'd5,
        MODE_BULK   = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DONE   = 2'd0,
        KIND_FIRE   = 2'd1,
        KIND_SWITCH = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_ALLOC = 2'd1,
        ST_RUN   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_NONE   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_POP    = 2'd3
    } cell_cmd_t;

    localparam logic CFG_TASK_INDEX  = 1'b0;
    localparam logic CFG_TASK_ENABLE = 1'b1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  timer_index;
        logic [31:0] delay;
        logic [7:0]  channel;
        logic [31:0] payload;
        logic        app_owned;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        success;
        logic [3:0]  result_index;
        logic [7:0]  out_channel;
        logic [31:0] out_payload;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic             v;
        logic [IDX_W-1:0] idx;
        logic [31:0]      dl;
    } cell_t;

    typedef struct packed {
        cell_cmd_t        cmd;
        logic [IDX_W-1:0] idx;
        logic [31:0]      dl;
    } cell_op_t;

endpackage

### hw/rtl/sorted_deadline_timer_queue.sv
// Allocate and bulk cancel walk the pool, one timer a cycle, visiting up to NUM_TIMERS timers.
// A tick bumps the count and pops each due timer; the list cells shift once per fire.
// One item is in work at a time; the output register lets the next item wait on output only.
// Reset clears the tick count, frees all timers, empties the list and zeroes the config.
module sorted_deadline_timer_queue #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdtq_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output sdtq_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [3:0]          cfg_data
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int IX = sdtq_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS,
        S_WALK,
        S_TICK,
        S_SW,
        S_DONE
    } state_t;

    state_t              state_reg;
    sdtq_pkg::in_item_t  item_reg;
    sdtq_pkg::out_item_t out_item_reg;
    logic                out_valid_reg;
    logic [31:0]         count_reg;
    logic [31:0]         dl_reg;
    logic [IX-1:0]       cnt_reg;
    logic                ok_reg;
    logic [3:0]          resi_reg;
    logic                sw_reg;
    logic [3:0]          tti_reg;
    logic                tte_reg;

    logic [1:0]  status_reg[NUM_TIMERS];
    logic        app_reg   [NUM_TIMERS];
    logic [7:0]  chan_reg  [NUM_TIMERS];
    logic [31:0] word_reg  [NUM_TIMERS];

    sdtq_pkg::cell_op_t op;
    sdtq_pkg::cell_t    head;
    sdtq_pkg::cell_t    second;

    logic [IW-1:0] rd_a;
    logic [IX-1:0] item_idx;
    logic          idx_ok;
    logic [1:0]    rd_status;
    logic          rd_app;
    logic [7:0]    rd_chan;
    logic [31:0]   rd_word;
    logic          head_due;
    logic          next_due;
    logic          can_emit;
    logic          is_task;
    logic          bulk_hit;
    logic          walk_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    assign item_idx  = IX'(item_reg.timer_index);
    assign idx_ok    = ({1'b0, item_idx} < (IX+1)'(NUM_TIMERS));
    assign head_due  = head.v && (head.dl <= count_reg);
    assign next_due  = second.v && (second.dl <= count_reg);
    assign can_emit  = !out_valid_reg || out_ready;
    assign is_task   = tte_reg && (head.idx == IX'(tti_reg));
    assign walk_last = (cnt_reg == IX'(NUM_TIMERS - 1));

    // One shared read address into the per-timer fields.
    always_comb
    begin
        case (state_reg)
            S_TICK:  rd_a = head.idx[IW-1:0];
            S_WALK:  rd_a = cnt_reg[IW-1:0];
            default: rd_a = item_idx[IW-1:0];
        endcase
    end

    assign rd_status = status_reg[rd_a];
    assign rd_app    = app_reg[rd_a];
    assign rd_chan   = chan_reg[rd_a];
    assign rd_word   = word_reg[rd_a];
    assign bulk_hit  = (rd_status != sdtq_pkg::ST_FREE) && rd_app
                       && (rd_chan == item_reg.channel);

    always_comb
    begin
        op = '{cmd: sdtq_pkg::CELL_NONE, idx: '0, dl: dl_reg};
        case (state_reg)
            S_DISPATCH:
            begin
                if (idx_ok && rd_status == sdtq_pkg::ST_RUN
                    && (item_reg.mode == sdtq_pkg::MODE_ARM
                        || item_reg.mode == sdtq_pkg::MODE_CANCEL
                        || item_reg.mode == sdtq_pkg::MODE_FREE))
                begin
                    op.cmd = sdtq_pkg::CELL_REMOVE;
                    op.idx = item_idx;
                end
            end
            S_INS:
            begin
                op.cmd = sdtq_pkg::CELL_INSERT;
                op.idx = item_idx;
            end
            S_WALK:
            begin
                if (item_reg.mode == sdtq_pkg::MODE_BULK && bulk_hit
                    && rd_status == sdtq_pkg::ST_RUN)
                begin
                    op.cmd = sdtq_pkg::CELL_REMOVE;
                    op.idx = cnt_reg;
                end
            end
            S_TICK:
            begin
                if (head_due && (is_task || can_emit))
                    op.cmd = sdtq_pkg::CELL_POP;
            end
            default:
            begin
                op.cmd = sdtq_pkg::CELL_NONE;
            end
        endcase
    end

    sdtq_chain #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .head   (head),
        .second (second)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DISPATCH && idx_ok && item_reg.mode == sdtq_pkg::MODE_SETUP)
        begin
            chan_reg[rd_a] <= item_reg.channel;
            word_reg[rd_a] <= item_reg.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            out_item_reg  <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            dl_reg        <= '0;
            cnt_reg       <= '0;
            ok_reg        <= 1'b0;
            resi_reg      <= '0;
            sw_reg        <= 1'b0;
            tti_reg       <= '0;
            tte_reg       <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                status_reg[i] <= sdtq_pkg::ST_FREE;
                app_reg[i]    <= 1'b0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == sdtq_pkg::CFG_TASK_INDEX)
                    tti_reg <= cfg_data;
                else
                    tte_reg <= cfg_data[0];
            end

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_item;
                        state_reg <= S_DISPATCH;
                    end
                end

                S_DISPATCH:
                begin
                    ok_reg   <= 1'b0;
                    resi_reg <= item_reg.timer_index;
                    cnt_reg  <= '0;
                    state_reg <= S_DONE;
                    case (item_reg.mode)
                        sdtq_pkg::MODE_TICK:
                        begin
                            count_reg <= count_reg + 32'd1;
                            sw_reg    <= 1'b0;
                            state_reg <= S_TICK;
                        end
                        sdtq_pkg::MODE_ALLOC, sdtq_pkg::MODE_BULK:
                        begin
                            resi_reg  <= '0;
                            state_reg <= S_WALK;
                        end
                        sdtq_pkg::MODE_SETUP:
                        begin
                            if (idx_ok)
                                app_reg[rd_a] <= item_reg.app_owned;
                        end
                        sdtq_pkg::MODE_ARM:
                        begin
                            if (idx_ok && rd_status != sdtq_pkg::ST_FREE)
                            begin
                                dl_reg    <= count_reg + item_reg.delay;
                                ok_reg    <= 1'b1;
                                state_reg <= S_INS;
                            end
                        end
                        sdtq_pkg::MODE_CANCEL:
                        begin
                            if (idx_ok && rd_status == sdtq_pkg::ST_RUN)
                            begin
                                status_reg[rd_a] <= sdtq_pkg::ST_ALLOC;
                                ok_reg           <= 1'b1;
                            end
                        end
                        sdtq_pkg::MODE_FREE:
                        begin
                            if (idx_ok && rd_status != sdtq_pkg::ST_FREE)
                            begin
                                status_reg[rd_a] <= sdtq_pkg::ST_FREE;
                                ok_reg           <= 1'b1;
                            end
                        end
                        default:
                        begin
                            ok_reg <= 1'b0;
                        end
                    endcase
                end

                S_INS:
                begin
                    status_reg[rd_a] <= sdtq_pkg::ST_RUN;
                    state_reg        <= S_DONE;
                end

                S_WALK:
                begin
                    if (item_reg.mode == sdtq_pkg::MODE_ALLOC)
                    begin
                        if (rd_status == sdtq_pkg::ST_FREE)
                        begin
                            status_reg[rd_a] <= sdtq_pkg::ST_ALLOC;
                            app_reg[rd_a]    <= 1'b0;
                            resi_reg         <= cnt_reg[3:0];
                            ok_reg           <= 1'b1;
                            state_reg        <= S_DONE;
                        end
                        else if (walk_last)
                            state_reg <= S_DONE;
                        else
                            cnt_reg <= cnt_reg + IX'(1);
                    end
                    else
                    begin
                        if (bulk_hit)
                        begin
                            status_reg[rd_a] <= sdtq_pkg::ST_FREE;
                            ok_reg           <= 1'b1;
                        end
                        if (walk_last)
                            state_reg <= S_DONE;
                        else
                            cnt_reg <= cnt_reg + IX'(1);
                    end
                end

                S_TICK:
                begin
                    // A post is the last beat when nothing else is due and no
                    // switch request is still owed behind it.
                    if (head_due)
                    begin
                        if (is_task)
                        begin
                            status_reg[rd_a] <= sdtq_pkg::ST_ALLOC;
                            sw_reg           <= 1'b1;
                            if (!next_due)
                                state_reg <= S_SW;
                        end
                        else if (can_emit)
                        begin
                            status_reg[rd_a] <= sdtq_pkg::ST_ALLOC;
                            out_valid_reg    <= 1'b1;
                            out_item_reg     <= '{kind: sdtq_pkg::KIND_FIRE, success: 1'b0,
                                                  result_index: head.idx[3:0],
                                                  out_channel: rd_chan,
                                                  out_payload: rd_word,
                                                  last: !next_due && !sw_reg};
                            if (!next_due)
                                state_reg <= sw_reg ? S_SW : S_IDLE;
                        end
                    end
                    else
                        state_reg <= sw_reg ? S_SW : S_IDLE;
                end

                S_SW:
                begin
                    if (can_emit)
                    begin
                        out_valid_reg <= 1'b1;
                        out_item_reg  <= '{kind: sdtq_pkg::KIND_SWITCH, success: 1'b0,
                                           result_index: tti_reg, out_channel: 8'd0,
                                           out_payload: 32'd0, last: 1'b1};
                        state_reg     <= S_IDLE;
                    end
                end

                S_DONE:
                begin
                    if (can_emit)
                    begin
                        out_valid_reg <= 1'b1;
                        out_item_reg  <= '{kind: sdtq_pkg::KIND_DONE, success: ok_reg,
                                           result_index: resi_reg, out_channel: 8'd0,
                                           out_payload: 32'd0, last: 1'b1};
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/sdtq_cell.sv
// One slot of the deadline-ordered list, shifting with its neighbors.
module sdtq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  sdtq_pkg::cell_op_t op,
    input  sdtq_pkg::cell_t    left,
    input  sdtq_pkg::cell_t    right,
    input  logic               left_ins,
    input  logic               hit_in,
    output sdtq_pkg::cell_t    data,
    output logic               ins_out,
    output logic               hit_out
);

    sdtq_pkg::cell_t cell_reg;
    sdtq_pkg::cell_t cell_next;

    // The list is sorted, so the insert condition is a step: the first cell
    // that meets it takes the new entry and the ones after it shift right.
    assign ins_out = !cell_reg.v || (cell_reg.dl >= op.dl);
    assign hit_out = hit_in || (cell_reg.v && (cell_reg.idx == op.idx));
    assign data    = cell_reg;

    always_comb
    begin
        cell_next = cell_reg;
        case (op.cmd)
            sdtq_pkg::CELL_INSERT:
            begin
                if (ins_out)
                begin
                    if (left_ins)
                        cell_next = left;
                    else
                        cell_next = '{v: 1'b1, idx: op.idx, dl: op.dl};
                end
            end
            sdtq_pkg::CELL_REMOVE:
            begin
                if (hit_out)
                    cell_next = right;
            end
            sdtq_pkg::CELL_POP:
            begin
                cell_next = right;
            end
            default:
            begin
                cell_next = cell_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else
            cell_reg <= cell_next;
    end

endmodule

### hw/rtl/sdtq_chain.sv
// Row of list cells holding running timers in deadline order.
module sdtq_chain #(
    parameter int NUM_TIMERS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sdtq_pkg::cell_op_t op,
    output sdtq_pkg::cell_t    head,
    output sdtq_pkg::cell_t    second
);

    sdtq_pkg::cell_t data [NUM_TIMERS];
    logic            ins_c[NUM_TIMERS];
    logic            hit_c[NUM_TIMERS];

    genvar k;
    generate
        for (k = 0; k < NUM_TIMERS; k++)
        begin : g_cell
            sdtq_pkg::cell_t left_d;
            sdtq_pkg::cell_t right_d;
            logic            left_ins;
            logic            hit_in;

            if (k == 0)
            begin : g_first
                assign left_d   = '0;
                assign left_ins = 1'b0;
                assign hit_in   = 1'b0;
            end
            else
            begin : g_mid
                assign left_d   = data[k-1];
                assign left_ins = ins_c[k-1];
                assign hit_in   = hit_c[k-1];
            end

            if (k == NUM_TIMERS - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_inner
                assign right_d = data[k+1];
            end

            sdtq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .op       (op),
                .left     (left_d),
                .right    (right_d),
                .left_ins (left_ins),
                .hit_in   (hit_in),
                .data     (data[k]),
                .ins_out  (ins_c[k]),
                .hit_out  (hit_c[k])
            );
        end
    endgenerate

    assign head   = data[0];
    assign second = data[1];

endmodule

### dv/sorted_deadline_timer_queue_tb.sv
// Self-checking testbench for the sorted deadline timer queue, with its own timer pool model.
module sorted_deadline_timer_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTIMERS = 16;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    typedef struct {
        sdtq_pkg::in_item_t item;
        bit                 drain;
    } pending_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    sdtq_pkg::in_item_t  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    sdtq_pkg::out_item_t out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = 1'b0;
    logic [3:0]          cfg_data = 4'd0;

    // Mirror of the block's state.
    logic [31:0]       tick_now;
    sdtq_pkg::status_t tm_status [NTIMERS];
    logic [31:0]       tm_deadline [NTIMERS];
    logic [7:0]        tm_channel [NTIMERS];
    logic [31:0]       tm_word [NTIMERS];
    logic              tm_app [NTIMERS];
    int                deadline_list [$];
    logic [3:0]        task_index_reg;
    logic              task_enable_reg;

    sdtq_pkg::out_item_t expected_results [$];
    pending_beat_t       pending_beats [$];
    bit                  fields_written [NTIMERS];
    bit                  calm;
    int                  error_count;
    int                  in_gap;
    int                  out_stall;

    sorted_deadline_timer_queue #(.NUM_TIMERS(NTIMERS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic void unlink_timer(int idx);
        for (int i = 0; i < deadline_list.size(); i++)
        begin
            if (deadline_list[i] == idx)
            begin
                deadline_list.delete(i);
                return;
            end
        end
    endfunction

    function automatic void link_timer(int idx);
        int pos;
        pos = 0;
        while (pos < deadline_list.size() && tm_deadline[deadline_list[pos]] < tm_deadline[idx])
            pos++;
        deadline_list.insert(pos, idx);
    endfunction

    function automatic sdtq_pkg::out_item_t make_result(sdtq_pkg::kind_t k, logic ok,
                                                        logic [3:0] idx, logic [7:0] ch,
                                                        logic [31:0] word);
        sdtq_pkg::out_item_t r;
        r.kind = k;
        r.success = ok;
        r.result_index = idx;
        r.out_channel = ch;
        r.out_payload = word;
        r.last = 1'b0;
        return r;
    endfunction

    // Works out every result of one accepted input beat and queues them.
    function automatic void predict_timers(sdtq_pkg::in_item_t it);
        sdtq_pkg::out_item_t res [$];
        bit                  want_switch;
        logic                ok;
        logic [3:0]          res_idx;
        int                  t;
        ok = 1'b0;
        res_idx = it.timer_index;
        want_switch = 0;
        if (it.mode == sdtq_pkg::MODE_TICK)
        begin
            tick_now = tick_now + 32'd1;
            while (deadline_list.size() > 0 && tm_deadline[deadline_list[0]] <= tick_now)
            begin
                t = deadline_list.pop_front();
                tm_status[t] = sdtq_pkg::ST_ALLOC;
                if (task_enable_reg && t == int'(task_index_reg))
                    want_switch = 1;
                else
                    res.push_back(make_result(sdtq_pkg::KIND_FIRE, 1'b0, 4'(t),
                                              tm_channel[t], tm_word[t]));
            end
            if (want_switch)
                res.push_back(make_result(sdtq_pkg::KIND_SWITCH, 1'b0, task_index_reg,
                                          '0, '0));
        end
        else
        begin
            t = int'(it.timer_index);
            case (it.mode)
                sdtq_pkg::MODE_ALLOC:
                begin
                    res_idx = '0;
                    for (int i = 0; i < NTIMERS; i++)
                    begin
                        if (tm_status[i] == sdtq_pkg::ST_FREE)
                        begin
                            tm_status[i] = sdtq_pkg::ST_ALLOC;
                            tm_app[i] = 1'b0;
                            res_idx = 4'(i);
                            ok = 1'b1;
                            break;
                        end
                    end
                end
                sdtq_pkg::MODE_SETUP:
                begin
                    tm_channel[t] = it.channel;
                    tm_word[t] = it.payload;
                    tm_app[t] = it.app_owned;
                end
                sdtq_pkg::MODE_ARM:
                begin
                    if (tm_status[t] != sdtq_pkg::ST_FREE)
                    begin
                        if (tm_status[t] == sdtq_pkg::ST_RUN)
                            unlink_timer(t);
                        tm_deadline[t] = tick_now + it.delay;
                        tm_status[t] = sdtq_pkg::ST_RUN;
                        link_timer(t);
                        ok = 1'b1;
                    end
                end
                sdtq_pkg::MODE_CANCEL:
                begin
                    if (tm_status[t] == sdtq_pkg::ST_RUN)
                    begin
                        unlink_timer(t);
                        tm_status[t] = sdtq_pkg::ST_ALLOC;
                        ok = 1'b1;
                    end
                end
                sdtq_pkg::MODE_FREE:
                begin
                    if (tm_status[t] != sdtq_pkg::ST_FREE)
                    begin
                        if (tm_status[t] == sdtq_pkg::ST_RUN)
                            unlink_timer(t);
                        tm_status[t] = sdtq_pkg::ST_FREE;
                        ok = 1'b1;
                    end
                end
                sdtq_pkg::MODE_BULK:
                begin
                    res_idx = '0;
                    for (int i = 0; i < NTIMERS; i++)
                    begin
                        if (tm_status[i] != sdtq_pkg::ST_FREE && tm_app[i] &&
                            tm_channel[i] == it.channel)
                        begin
                            if (tm_status[i] == sdtq_pkg::ST_RUN)
                                unlink_timer(i);
                            tm_status[i] = sdtq_pkg::ST_FREE;
                            ok = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            res.push_back(make_result(sdtq_pkg::KIND_DONE, ok, res_idx, '0, '0));
        end
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            expected_results.push_back(res[i]);
    endfunction

    // Input driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_timers(in_item);
                in_gap = draw_wait();
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap != 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() > 0 &&
                         !(pending_beats[0].drain && expected_results.size() != 0))
                begin
                    in_item <= pending_beats[0].item;
                    void'(pending_beats.pop_front());
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result %p", out_item));
                else
                begin
                    sdtq_pkg::out_item_t want;
                    want = expected_results.pop_front();
                    if (out_item.kind !== want.kind || out_item.success !== want.success ||
                        out_item.result_index !== want.result_index ||
                        out_item.out_channel !== want.out_channel ||
                        out_item.out_payload !== want.out_payload ||
                        out_item.last !== want.last)
                        report_mismatch($sformatf("got %p want %p", out_item, want));
                end
                out_stall = draw_wait();
            end
            else if (out_stall != 0)
                out_stall = out_stall - 1;
            out_ready <= (out_stall == 0);
        end
    end

    function automatic sdtq_pkg::in_item_t make_beat(logic [2:0] mode, logic [3:0] idx,
                                                     logic [31:0] dly, logic [7:0] ch,
                                                     logic [31:0] word, logic app);
        sdtq_pkg::in_item_t it;
        it.mode = mode;
        it.timer_index = idx;
        it.delay = dly;
        it.channel = ch;
        it.payload = word;
        it.app_owned = app;
        return it;
    endfunction

    task automatic queue_beat(sdtq_pkg::in_item_t it, bit drain);
        pending_beat_t p;
        p.item = it;
        p.drain = drain;
        if (it.mode == sdtq_pkg::MODE_SETUP)
            fields_written[it.timer_index] = 1;
        pending_beats.push_back(p);
    endtask

    task automatic queue_random(int count, int drain_at);
        sdtq_pkg::in_item_t it;
        int                 pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            it = make_beat(sdtq_pkg::MODE_TICK, 4'($urandom_range(0, NTIMERS - 1)), $urandom,
                           8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 3)),
                           $urandom, 1'($urandom_range(0, 1)));
            if (pick < 35)
                it.mode = sdtq_pkg::MODE_TICK;
            else if (pick < 45)
                it.mode = sdtq_pkg::MODE_ALLOC;
            else if (pick < 60)
                it.mode = sdtq_pkg::MODE_SETUP;
            else if (pick < 80)
                it.mode = sdtq_pkg::MODE_ARM;
            else if (pick < 86)
                it.mode = sdtq_pkg::MODE_CANCEL;
            else if (pick < 92)
                it.mode = sdtq_pkg::MODE_FREE;
            else if (pick < 97)
                it.mode = sdtq_pkg::MODE_BULK;
            else
                it.mode = MODE_UNUSED;
            if (it.mode == sdtq_pkg::MODE_ARM)
            begin
                // Never let a timer fire with channel and payload unwritten.
                if (!fields_written[it.timer_index])
                    it.mode = sdtq_pkg::MODE_SETUP;
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    it.delay = $urandom_range(0, 15);
                else if (pick == 7)
                    it.delay = 32'hffff_ffff - $urandom_range(0, 3);
            end
            if (n % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            queue_beat(it, n == drain_at);
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
        // A quiet tick gives no result, so leave time for it to finish.
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] data);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == sdtq_pkg::CFG_TASK_INDEX)
            task_index_reg = data;
        else
            task_enable_reg = data[0];
    endtask

    initial
    begin
        tick_now = '0;
        task_index_reg = '0;
        task_enable_reg = 1'b0;
        error_count = 0;
        calm = 0;
        for (int i = 0; i < NTIMERS; i++)
        begin
            tm_status[i] = sdtq_pkg::ST_FREE;
            tm_deadline[i] = '0;
            tm_channel[i] = '0;
            tm_word[i] = '0;
            tm_app[i] = 1'b0;
            fields_written[i] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(sdtq_pkg::CFG_TASK_INDEX, 4'd2);
        write_reg(sdtq_pkg::CFG_TASK_ENABLE, 4'd0);
        queue_beat(make_beat(sdtq_pkg::MODE_ALLOC, 0, 0, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_ALLOC, 0, 0, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_ALLOC, 0, 0, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_SETUP, 0, 0, 8'h00, 32'h0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_SETUP, 1, 0, 8'hff, 32'hffff_ffff, 1), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_SETUP, 2, 32'hffff_ffff, 8'hff, 32'h1234_5678, 1),
                   0);
        queue_beat(make_beat(sdtq_pkg::MODE_ARM, 0, 32'h0, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_ARM, 1, 32'hffff_ffff, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_ARM, 2, 32'd5, 0, 0, 0), 0);
        // Re-arming a running timer moves it ahead of an equal deadline.
        queue_beat(make_beat(sdtq_pkg::MODE_ARM, 2, 32'd0, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_ARM, 3, 32'd1, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_CANCEL, 3, 0, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_TICK, 0, 0, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_TICK, 0, 0, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_ARM, 1, 32'd3, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_FREE, 1, 0, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_ARM, 2, 32'd9, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_CANCEL, 2, 0, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_BULK, 0, 0, 8'hff, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_BULK, 0, 0, 8'hff, 0, 0), 0);
        queue_beat(make_beat(MODE_UNUSED, 4'hf, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 1), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_FREE, 5, 0, 0, 0, 0), 0);
        queue_beat(make_beat(sdtq_pkg::MODE_TICK, 4'hf, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 1),
                   0);
        wait_idle();

        write_reg(sdtq_pkg::CFG_TASK_INDEX, 4'd2);
        write_reg(sdtq_pkg::CFG_TASK_ENABLE, 4'd1);
        queue_random(150, -1);
        wait_idle();

        write_reg(sdtq_pkg::CFG_TASK_INDEX, 4'd15);
        queue_random(160, 80);
        wait_idle();

        write_reg(sdtq_pkg::CFG_TASK_INDEX, 4'd0);
        write_reg(sdtq_pkg::CFG_TASK_ENABLE, 4'd0);
        queue_random(160, -1);
        wait_idle();

        if (expected_results.size() != 0)
            report_mismatch("results still outstanding at end of run");
        if (error_count == 0)
            $display("sorted_deadline_timer_queue test passed");
        else
            $display("sorted_deadline_timer_queue test failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("sorted_deadline_timer_queue test failed");
        $finish;
    end

endmodule
